>>> hdl/sliding_window_median_cost_unit_assert.svh
// Assertion macros used by the datapath RTL of the sliding window median cost unit.
`ifndef SLIDING_WINDOW_MEDIAN_COST_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_COST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SWMC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/swmc_pkg.sv
package swmc_pkg;

   // Field widths of the ports.
   localparam int unsigned SAMPLE_W       = 30;
   localparam int unsigned COST_W         = 40;
   localparam int unsigned WSIZE_W        = 11;
   localparam int unsigned WINDOW_MAX_DEF = 1024;

   // Datapath operations issued by the controller, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_OLD_RD,
      OP_OLD_CAP,
      OP_DL_RD,
      OP_DL_CMP,
      OP_DL_END,
      OP_IS_INIT,
      OP_IS_RD,
      OP_IS_CMP,
      OP_IS_END,
      OP_SM_INIT,
      OP_SM_RD,
      OP_SM_ACC,
      OP_MUL,
      OP_COST_EMIT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      emit;
   } dp_cmd_type;

   typedef struct packed {
      logic at_fill;
      logic need_drop;
      logic full;
      logic rsp_free;
   } dp_stat_type;

endpackage

>>> hdl/sliding_window_median_cost_unit.sv
// Channel   Handshake                Word
// req       req_valid / req_ready    req_sample (30 bits)
// rsp       rsp_valid / rsp_ready    rsp_cost (40 bits)
// csr       csr_valid / csr_ready    csr_wdata (11 bits, window size)
// After acceptance a sample drops the oldest held samples while the held count reaches the size,
// is then inserted into the sorted RAM, and the sums of both halves give a cost that is emitted
// only when the window is full. Each sorted pass reads one word at a time through the single
// registered read port of the sorted RAM.
// Reset is synchronous, clears the counters and sets the window size to one; no RAM clearing pass.
// A finished cost waits in the output register while the next sample is taken; a new cost
// stalls until that word is accepted.
module sliding_window_median_cost_unit #(
   parameter int unsigned WINDOW_MAX = swmc_pkg::WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [swmc_pkg::SAMPLE_W-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swmc_pkg::COST_W-1:0]   rsp_cost,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [swmc_pkg::WSIZE_W-1:0]  csr_wdata
);
   import swmc_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // The window size register takes a write in any cycle.
   assign csr_ready = 1'b1;

   swmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   swmc_datapath #(.WINDOW_MAX(WINDOW_MAX)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_sample (req_sample),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_cost   (rsp_cost)
   );

endmodule

>>> hdl/swmc_ram.sv
module swmc_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

>>> hdl/swmc_datapath.sv
`include "sliding_window_median_cost_unit_assert.svh"

module swmc_datapath #(
   parameter int unsigned WINDOW_MAX = swmc_pkg::WINDOW_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swmc_pkg::dp_cmd_type          cmd,
   output swmc_pkg::dp_stat_type         stat,
   input  logic [swmc_pkg::SAMPLE_W-1:0] req_sample,
   input  logic                          csr_valid,
   input  logic [swmc_pkg::WSIZE_W-1:0]  csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [swmc_pkg::COST_W-1:0]   rsp_cost
);
   import swmc_pkg::*;

   localparam int unsigned CW = $clog2(WINDOW_MAX + 1);
   localparam int unsigned AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [CW-1:0]       ws_ff, ws_in, fill_ff, fill_in, idx_ff, idx_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic                found_ff, found_in, rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] new_ff, new_in, old_ff, old_in, hold_ff, hold_in;
   logic [SAMPLE_W-1:0] med_ff, med_in;
   logic [COST_W-1:0]   lsum_ff, lsum_in, usum_ff, usum_in;
   logic [COST_W-1:0]   pl_ff, pl_in, pr_ff, pr_in, out_ff, out_in;

   logic                srt_we, ring_we;
   logic [AW-1:0]       srt_waddr, ring_raddr;
   logic [SAMPLE_W-1:0] srt_wdata, srt_rdata, ring_rdata;
   logic [CW:0]         old_pos, cnt_sum;
   logic [CW-1:0]       cntl, cntr;

   // Sorted window and arrival ring.
   swmc_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_sorted (
      .clock (clock),
      .we    (srt_we),
      .waddr (srt_waddr),
      .wdata (srt_wdata),
      .raddr (idx_ff[AW-1:0]),
      .rdata (srt_rdata)
   );

   swmc_ram #(.WIDTH(SAMPLE_W), .DEPTH(WINDOW_MAX)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ptr_ff),
      .wdata (new_ff),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   // Ring slot of the oldest held sample, and the median split counts.
   always_comb begin
      old_pos = (CW+1)'(ptr_ff) + (CW+1)'(WINDOW_MAX) - (CW+1)'(fill_ff);
      if (old_pos >= (CW+1)'(WINDOW_MAX)) begin
         old_pos = old_pos - (CW+1)'(WINDOW_MAX);
      end
      ring_raddr = old_pos[AW-1:0];
      cnt_sum    = ((CW+1)'(fill_ff) + (CW+1)'(1)) >> 1;
      cntl       = cnt_sum[CW-1:0];
      cntr       = fill_ff - cntl;
   end

   // Status back to the controller.
   always_comb begin
      stat.at_fill   = (idx_ff == fill_ff);
      stat.need_drop = (fill_ff >= ws_ff) && (fill_ff != '0);
      stat.full      = (fill_ff == ws_ff);
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   // Next-state logic for every datapath operation.
   always_comb begin
      ws_in        = ws_ff;
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      ptr_in       = ptr_ff;
      found_in     = found_ff;
      new_in       = new_ff;
      old_in       = old_ff;
      hold_in      = hold_ff;
      med_in       = med_ff;
      lsum_in      = lsum_ff;
      usum_in      = usum_ff;
      pl_in        = pl_ff;
      pr_in        = pr_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff;
      srt_we       = 1'b0;
      srt_waddr    = idx_ff[AW-1:0];
      srt_wdata    = hold_ff;
      ring_we      = 1'b0;

      // Window size write, with zero taken as one and saturation at the maximum.
      if (csr_valid) begin
         if (csr_wdata == '0) begin
            ws_in = CW'(1);
         end else if (32'(csr_wdata) > WINDOW_MAX) begin
            ws_in = CW'(WINDOW_MAX);
         end else begin
            ws_in = CW'(csr_wdata);
         end
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (cmd.op)
         OP_LOAD: begin
            new_in = req_sample;
         end
         OP_OLD_CAP: begin
            old_in   = ring_rdata;
            idx_in   = '0;
            found_in = 1'b0;
         end
         OP_DL_CMP: begin
            // After the match, each later word moves down one place.
            if (found_ff) begin
               srt_we    = 1'b1;
               srt_waddr = AW'(idx_ff - CW'(1));
               srt_wdata = srt_rdata;
            end else if (srt_rdata == old_ff) begin
               found_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         OP_DL_END: begin
            fill_in = fill_ff - CW'(1);
         end
         OP_IS_INIT: begin
            idx_in   = '0;
            found_in = 1'b0;
            hold_in  = new_ff;
         end
         OP_IS_CMP: begin
            // From the first larger word on, words ripple up one place.
            if (found_ff || (srt_rdata > new_ff)) begin
               srt_we   = 1'b1;
               hold_in  = srt_rdata;
               found_in = 1'b1;
            end
            idx_in = idx_ff + CW'(1);
         end
         OP_IS_END: begin
            srt_we  = 1'b1;
            ring_we = 1'b1;
            fill_in = fill_ff + CW'(1);
            if (ptr_ff == AW'(WINDOW_MAX - 1)) begin
               ptr_in = '0;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         OP_SM_INIT: begin
            idx_in  = '0;
            lsum_in = '0;
            usum_in = '0;
         end
         OP_SM_ACC: begin
            if (idx_ff < cntl) begin
               lsum_in = lsum_ff + COST_W'(srt_rdata);
            end else begin
               usum_in = usum_ff + COST_W'(srt_rdata);
            end
            if (idx_ff == cntl - CW'(1)) begin
               med_in = srt_rdata;
            end
            idx_in = idx_ff + CW'(1);
         end
         OP_MUL: begin
            pl_in = COST_W'(med_ff) * COST_W'(cntl);
            pr_in = COST_W'(med_ff) * COST_W'(cntr);
         end
         OP_COST_EMIT: begin
            if (cmd.emit) begin
               out_in       = (pl_ff - lsum_ff) + (usum_ff - pr_ff);
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff        <= CW'(1);
         fill_ff      <= '0;
         ptr_ff       <= '0;
         idx_ff       <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ws_ff        <= ws_in;
         fill_ff      <= fill_in;
         ptr_ff       <= ptr_in;
         idx_ff       <= idx_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      new_ff  <= new_in;
      old_ff  <= old_in;
      hold_ff <= hold_in;
      med_ff  <= med_in;
      lsum_ff <= lsum_in;
      usum_ff <= usum_in;
      pl_ff   <= pl_in;
      pr_ff   <= pr_in;
      out_ff  <= out_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cost  = out_ff;

   `SWMC_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CW'(WINDOW_MAX), "fill count above maximum")
   `SWMC_ASSERT_NOW(a_drop_nonempty, clock, reset, cmd.op == OP_DL_END, fill_ff != '0, "drop from empty window")
   `SWMC_ASSERT_NEXT(a_drop_shrinks, clock, reset, cmd.op == OP_DL_END, fill_ff < $past(fill_ff), "drop did not shrink window")
   `SWMC_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.op == OP_IS_END, fill_ff > $past(fill_ff), "insert did not grow window")
   `SWMC_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.emit, !rsp_valid_ff || rsp_ready, "result word overwritten")

endmodule

>>> hdl/swmc_ctrl.sv
module swmc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swmc_pkg::dp_stat_type stat,
   output swmc_pkg::dp_cmd_type  cmd
);
   import swmc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHK,
      ST_OLD_CAP,
      ST_DL_RD,
      ST_DL_CMP,
      ST_IS_RD,
      ST_IS_CMP,
      ST_SM_INIT,
      ST_SM_RD,
      ST_SM_ACC,
      ST_COST,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;

   // Sequencing of drop, insert, sum and result phases.
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      cmd.emit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (stat.need_drop) begin
               cmd.op   = OP_OLD_RD;
               state_in = ST_OLD_CAP;
            end else begin
               cmd.op   = OP_IS_INIT;
               state_in = ST_IS_RD;
            end
         end
         ST_OLD_CAP: begin
            cmd.op   = OP_OLD_CAP;
            state_in = ST_DL_RD;
         end
         ST_DL_RD: begin
            if (stat.at_fill) begin
               cmd.op   = OP_DL_END;
               state_in = ST_CHK;
            end else begin
               cmd.op   = OP_DL_RD;
               state_in = ST_DL_CMP;
            end
         end
         ST_DL_CMP: begin
            cmd.op   = OP_DL_CMP;
            state_in = ST_DL_RD;
         end
         ST_IS_RD: begin
            if (stat.at_fill) begin
               cmd.op   = OP_IS_END;
               state_in = ST_SM_INIT;
            end else begin
               cmd.op   = OP_IS_RD;
               state_in = ST_IS_CMP;
            end
         end
         ST_IS_CMP: begin
            cmd.op   = OP_IS_CMP;
            state_in = ST_IS_RD;
         end
         ST_SM_INIT: begin
            cmd.op   = OP_SM_INIT;
            state_in = ST_SM_RD;
         end
         ST_SM_RD: begin
            if (stat.at_fill) begin
               cmd.op   = OP_MUL;
               state_in = ST_COST;
            end else begin
               cmd.op   = OP_SM_RD;
               state_in = ST_SM_ACC;
            end
         end
         ST_SM_ACC: begin
            cmd.op   = OP_SM_ACC;
            state_in = ST_SM_RD;
         end
         ST_COST: begin
            state_in = stat.full ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_COST_EMIT;
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

>>> test/testbench.sv
module testbench;
   import swmc_pkg::*;

   localparam int unsigned WIN_LIMIT = WINDOW_MAX_DEF;
   // Cycles the block may still spend on a sample that causes no result.
   localparam int unsigned SETTLE = 4 * (WIN_LIMIT + 1) + 64;

   typedef struct {
      bit                  is_csr;
      logic [WSIZE_W-1:0]  wsize;
      logic [SAMPLE_W-1:0] sample;
   } word_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic [SAMPLE_W-1:0] req_sample;
   logic rsp_valid;
   logic rsp_ready;
   logic [COST_W-1:0] rsp_cost;
   logic csr_valid;
   logic csr_ready;
   logic [WSIZE_W-1:0] csr_wdata;

   word_type            pending_words[$];
   logic [COST_W-1:0]   expected_costs[$];
   logic [SAMPLE_W-1:0] held_samples[$];
   int unsigned         window_len;
   int unsigned         quiet_cycles;
   int unsigned         req_gap;
   int unsigned         rsp_gap;
   bit                  req_fired;
   bit                  csr_fired;
   bit                  calm;
   int unsigned         error_count;

   sliding_window_median_cost_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_cost(rsp_cost),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   // Sum of absolute deviations of the held samples from their lower median.
   function automatic logic [COST_W-1:0] median_deviation_sum();
      logic [SAMPLE_W-1:0] ordered[$];
      logic [COST_W-1:0] total;
      logic [SAMPLE_W-1:0] median;
      total = '0;
      ordered = held_samples;
      ordered.sort();
      median = ordered[(ordered.size() + 1) / 2 - 1];
      foreach (ordered[i]) begin
         if (ordered[i] > median)
            total += COST_W'(ordered[i] - median);
         else
            total += COST_W'(median - ordered[i]);
      end
      return total;
   endfunction

   task automatic add_csr(input int unsigned value);
      word_type w;
      w.is_csr = 1'b1;
      w.wsize  = WSIZE_W'(value);
      w.sample = '0;
      pending_words.push_back(w);
   endtask

   task automatic add_sample(input logic [SAMPLE_W-1:0] value);
      word_type w;
      w.is_csr = 1'b0;
      w.wsize  = '0;
      w.sample = value;
      pending_words.push_back(w);
   endtask

   function automatic logic [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(0, 3))
         0: return SAMPLE_W'($urandom_range(0, 7));
         1: return {SAMPLE_W{1'b1}} - SAMPLE_W'($urandom_range(0, 3));
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Stimulus list: directed words first, then random phases, then a saturated write
   // and a long window.
   initial begin
      int unsigned wsize;
      int unsigned count;
      reset = 1'b1;
      calm  = 1'b0;
      add_sample('0);
      add_sample({SAMPLE_W{1'b1}});
      add_sample(SAMPLE_W'($urandom()));
      add_csr(0);
      add_sample(SAMPLE_W'(12345));
      add_sample('0);
      add_csr(2);
      add_sample('0);
      add_sample({SAMPLE_W{1'b1}});
      add_sample({SAMPLE_W{1'b1}});
      add_sample('0);
      add_csr(5);
      add_sample(SAMPLE_W'(7));
      add_sample(SAMPLE_W'(7));
      add_sample({SAMPLE_W{1'b1}});
      add_sample('0);
      add_sample(SAMPLE_W'(3));
      add_sample(SAMPLE_W'(9));
      add_csr(3);
      add_sample(SAMPLE_W'(1));
      add_sample({SAMPLE_W{1'b1}});
      add_csr(4);
      add_sample(SAMPLE_W'(2));
      add_sample(SAMPLE_W'(2));
      for (int p = 0; p < 18; p++) begin
         if ($urandom_range(0, 5) == 0)
            wsize = $urandom_range(17, 64);
         else
            wsize = $urandom_range(0, 16);
         add_csr(wsize);
         count = $urandom_range(20, 40);
         for (int i = 0; i < count; i++)
            add_sample(random_sample());
      end
      // A write above the maximum saturates, so these words never fill the window.
      add_csr({WSIZE_W{1'b1}});
      for (int i = 0; i < 20; i++)
         add_sample(random_sample());
      add_csr(300);
      for (int i = 0; i < 330; i++)
         add_sample(random_sample());
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: one word at a time on the sample or register channel.
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         req_valid  <= 1'b0;
         req_sample <= '0;
         csr_valid  <= 1'b0;
         csr_wdata  <= '0;
         rsp_ready  <= 1'b0;
         req_gap = 0;
         rsp_gap = 0;
      end else begin
         if ((req_valid && !req_fired) || (csr_valid && !csr_fired)) begin
            // Hold the current word until it is taken.
         end else if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else if (pending_words.size() == 0) begin
            req_valid <= 1'b0;
            csr_valid <= 1'b0;
         end else if (pending_words[0].is_csr) begin
            req_valid <= 1'b0;
            // Register writes wait until the block has gone quiet.
            if (expected_costs.size() == 0 && quiet_cycles >= SETTLE && !req_valid) begin
               w = pending_words.pop_front();
               csr_valid <= 1'b1;
               csr_wdata <= w.wsize;
            end else begin
               csr_valid <= 1'b0;
            end
         end else begin
            w = pending_words.pop_front();
            csr_valid  <= 1'b0;
            req_valid  <= 1'b1;
            req_sample <= w.sample;
            if (!calm && $urandom_range(0, 3) == 0)
               req_gap = $urandom_range(1, 4);
         end
         // Result side back-pressure in short bursts.
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_gap = $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: predicts on accepted words and checks every result.
   always @(posedge clock) begin
      logic [COST_W-1:0] want;
      req_fired = 1'b0;
      csr_fired = 1'b0;
      if (reset) begin
         window_len = 1;
         held_samples.delete();
         quiet_cycles = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            csr_fired = 1'b1;
            window_len = csr_wdata;
            if (window_len == 0)
               window_len = 1;
            if (window_len > WIN_LIMIT)
               window_len = WIN_LIMIT;
         end
         if (req_valid && req_ready) begin
            req_fired = 1'b1;
            while (held_samples.size() >= window_len)
               void'(held_samples.pop_front());
            held_samples.push_back(req_sample);
            if (held_samples.size() == window_len)
               expected_costs.push_back(median_deviation_sum());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_costs.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual cost %0d",
                        $time, rsp_cost);
               error_count++;
            end else begin
               want = expected_costs.pop_front();
               if (rsp_cost !== want) begin
                  $display("%0t: cost mismatch, expected %0d, actual %0d",
                           $time, want, rsp_cost);
                  error_count++;
               end
            end
         end
         if (req_fired || expected_costs.size() != 0)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
   end

   // End of run once every word is taken and every result has come.
   initial begin
      error_count = 0;
      @(negedge reset);
      // The last stretch of words runs without idle cycles.
      wait (pending_words.size() <= 100);
      calm = 1'b1;
      wait (pending_words.size() == 0 && !req_valid && !csr_valid
            && expected_costs.size() == 0);
      repeat (SETTLE) @(posedge clock);
      if (expected_costs.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, expected_costs.size());
         error_count++;
      end
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Watchdog.
   initial begin
      #40000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
